// File: hdl/cll_pkg.sv
// Shared types, codes and sizes of the combination lock.
`default_nettype none
package cll_pkg;

    localparam int CODE_LENGTH = 6;
    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam int ADDR_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [CNT_W-1:0] CODE_LAST = CNT_W'(CODE_LENGTH - 1);
    localparam logic [CNT_W-1:0] CODE_FULL = CNT_W'(CODE_LENGTH);

    localparam logic [1:0] CMD_KEY = 2'd0;
    localparam logic [1:0] CMD_BLINK = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_ONE = 2'd1;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_STORED = 3'd1;
    localparam logic [2:0] EV_ACCEPTED = 3'd2;
    localparam logic [2:0] EV_REJECTED = 3'd3;
    localparam logic [2:0] EV_LOCKOUT_OVER = 3'd4;
    localparam logic [2:0] EV_CLOSED = 3'd5;

    localparam logic [1:0] CFG_SHORT_TICKS = 2'd0;
    localparam logic [1:0] CFG_LONG_TICKS = 2'd1;
    localparam logic [1:0] CFG_ERROR_LIMIT = 2'd2;

    localparam logic [15:0] SHORT_TICKS_RESET = 16'd16;
    localparam logic [15:0] LONG_TICKS_RESET = 16'd40;
    localparam logic [3:0] ERROR_LIMIT_RESET = 4'd3;
    localparam logic [3:0] ERROR_MAX = 4'd15;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] digits_entered;
        logic [2:0] event_res;
        logic [2:0] leds;
    } t_out_word;

    typedef struct packed {
        logic [15:0] short_lockout_ticks;
        logic [15:0] long_lockout_ticks;
        logic [3:0]  error_limit;
    } t_cfg;

endpackage
`default_nettype wire

// File: hdl/combination_lock_with_lockout_top.sv
// Top level of the combination lock with lockout: configuration registers and block wiring.
`default_nettype none
// The lock takes one word per clock cycle while the output buffer has space,
// and registers each result word there. The stored code sits in a small
// synchronous memory whose read for the next digit is issued in the same cycle
// the digit count updates, so consecutive key words need no wait. A two-entry
// output buffer keeps input accepted while a result waits. The code memory needs
// no clearing after reset; setup writes every digit before the code is compared.
module combination_lock_with_lockout_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire cll_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output cll_pkg::t_out_word      o_out_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    import cll_pkg::*;

    t_cfg              r_cfg;
    logic              fire;
    logic              space;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [1:0]        wdata;
    logic [1:0]        rdata;
    t_out_word         result;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = space;
    assign fire = i_in_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_lockout_ticks <= SHORT_TICKS_RESET;
            r_cfg.long_lockout_ticks <= LONG_TICKS_RESET;
            r_cfg.error_limit <= ERROR_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SHORT_TICKS: r_cfg.short_lockout_ticks <= i_cfg_data;
                CFG_LONG_TICKS:  r_cfg.long_lockout_ticks <= i_cfg_data;
                CFG_ERROR_LIMIT: r_cfg.error_limit <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    cll_code_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cll_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (i_in_word),
        .i_cfg    (r_cfg),
        .i_rdata  (rdata),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .o_result (result)
    );

    cll_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fire),
        .i_word  (result),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule
`default_nettype wire

// File: hdl/cll_code_mem.sv
// Synchronous code memory with a registered read and write-to-read forwarding.
`default_nettype none
module cll_code_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [cll_pkg::ADDR_W-1:0] i_waddr,
    input  wire logic [1:0]                i_wdata,
    input  wire logic [cll_pkg::ADDR_W-1:0] i_raddr,
    output logic [1:0]                     o_rdata
);
    import cll_pkg::*;

    logic [1:0] r_mem [CODE_LENGTH];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hdl/cll_ctrl.sv
// Lock state machine that reads, checks and updates the stored code per input word.
`default_nettype none
module cll_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire cll_pkg::t_in_word          i_word,
    input  wire cll_pkg::t_cfg              i_cfg,
    input  wire logic [1:0]                 i_rdata,
    output logic                            o_we,
    output logic [cll_pkg::ADDR_W-1:0]      o_waddr,
    output logic [1:0]                      o_wdata,
    output logic [cll_pkg::ADDR_W-1:0]      o_raddr,
    output cll_pkg::t_out_word              o_result
);
    import cll_pkg::*;

    typedef enum logic [1:0] {
        SETUP   = 2'd0,
        LOCKED  = 2'd1,
        BLOCKED = 2'd2,
        OPEN    = 2'd3
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_dc, n_dc;
    logic             r_mm, n_mm;
    logic [3:0]       r_err, n_err;
    logic [15:0]      r_timer, n_timer;
    logic [2:0]       r_leds, n_leds;
    logic [2:0]       ev;
    logic             key_hit;
    logic             mm_now;

    always_comb begin
        n_mode = r_mode;
        n_dc = r_dc;
        n_mm = r_mm;
        n_err = r_err;
        n_timer = r_timer;
        n_leds = r_leds;
        ev = EV_NONE;
        o_we = 1'b0;
        key_hit = (i_word.cmd == CMD_KEY) && (i_word.key != KEY_NONE);
        mm_now = r_mm | ((r_dc < CODE_FULL) && (i_rdata != i_word.key));
        if (i_fire) begin
            case (r_mode)
                SETUP: begin
                    if (i_word.cmd == CMD_BLINK) begin
                        n_leds = r_leds ^ 3'b101;
                    end else if (key_hit) begin
                        o_we = 1'b1;
                        if (r_dc >= CODE_LAST) begin
                            n_mode = LOCKED;
                            n_dc = '0;
                            n_mm = 1'b0;
                            n_leds = 3'b000;
                            ev = EV_STORED;
                        end else begin
                            n_dc = r_dc + CNT_W'(1);
                        end
                    end
                end
                LOCKED: begin
                    if (key_hit) begin
                        if (r_dc >= CODE_LAST) begin
                            n_mm = 1'b0;
                            if (!mm_now) begin
                                n_mode = OPEN;
                                n_dc = '0;
                                n_err = '0;
                                n_leds = 3'b111;
                                ev = EV_ACCEPTED;
                            end else begin
                                n_timer = (r_err >= i_cfg.error_limit) ?
                                          i_cfg.long_lockout_ticks :
                                          i_cfg.short_lockout_ticks;
                                if (r_err != ERROR_MAX) begin
                                    n_err = r_err + 4'd1;
                                end
                                n_mode = BLOCKED;
                                n_dc = CODE_FULL;
                                n_leds = 3'b000;
                                ev = EV_REJECTED;
                            end
                        end else begin
                            n_mm = mm_now;
                            n_dc = r_dc + CNT_W'(1);
                        end
                    end
                end
                BLOCKED: begin
                    if (i_word.cmd == CMD_BLINK) begin
                        n_leds = r_leds ^ 3'b111;
                    end else if (i_word.cmd == CMD_TICK) begin
                        if (r_timer <= 16'd1) begin
                            n_timer = '0;
                            n_mode = LOCKED;
                            n_dc = '0;
                            n_mm = 1'b0;
                            n_leds = 3'b000;
                            ev = EV_LOCKOUT_OVER;
                        end else begin
                            n_timer = r_timer - 16'd1;
                        end
                    end
                end
                OPEN: begin
                    if ((i_word.cmd == CMD_KEY) && (i_word.key == KEY_ONE)) begin
                        n_mode = LOCKED;
                        n_dc = '0;
                        n_mm = 1'b0;
                        n_leds = 3'b000;
                        ev = EV_CLOSED;
                    end
                end
                default: begin
                    n_mode = SETUP;
                end
            endcase
        end
    end

    // The read address follows the digit count the next word will see, or is zero once the count is full.
    always_comb begin
        o_waddr = r_dc[ADDR_W-1:0];
        o_wdata = i_word.key;
        if (n_dc < CODE_FULL) begin
            o_raddr = n_dc[ADDR_W-1:0];
        end else begin
            o_raddr = '0;
        end
        o_result.mode = n_mode;
        o_result.digits_entered = 3'(n_dc);
        o_result.event_res = ev;
        o_result.leds = n_leds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= SETUP;
            r_dc <= '0;
            r_mm <= 1'b0;
            r_err <= '0;
            r_timer <= '0;
            r_leds <= '0;
        end else begin
            r_mode <= n_mode;
            r_dc <= n_dc;
            r_mm <= n_mm;
            r_err <= n_err;
            r_timer <= n_timer;
            r_leds <= n_leds;
        end
    end

endmodule
`default_nettype wire

// File: hdl/cll_out_buf.sv
// Output register with a skid stage for result words.
`default_nettype none
module cll_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire cll_pkg::t_out_word i_word,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cll_pkg::t_out_word      o_word
);
    import cll_pkg::*;

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_word r_main;
    t_out_word r_skid;
    logic      main_free;

    assign main_free = !r_main_valid || i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_word = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            r_main_valid <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_word;
        end else if (i_valid) begin
            r_skid <= i_word;
        end
    end

endmodule
`default_nettype wire

// File: bench/combination_lock_with_lockout_top_tb.sv
// Self-checking testbench of the combination lock: shadow model, scoreboard and random traffic.
module combination_lock_with_lockout_top_tb;
    import cll_pkg::*;

    typedef enum logic [1:0] {
        LOCK_SETUP   = 2'd0,
        LOCK_ENTRY   = 2'd1,
        LOCK_BLOCKED = 2'd2,
        LOCK_OPEN    = 2'd3
    } lock_state_e;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RUN_LIMIT = 2_000_000;

    class lock_shadow;
        logic [15:0] short_ticks;
        logic [15:0] long_ticks;
        logic [3:0]  err_limit;
        lock_state_e mode;
        int          digits;
        logic [1:0]  code [CODE_LENGTH];
        bit          mismatch;
        logic [3:0]  errors;
        logic [15:0] timer;
        logic [2:0]  leds;
        t_out_word   status_due [$];
        int          faults;

        function new();
            short_ticks = SHORT_TICKS_RESET;
            long_ticks = LONG_TICKS_RESET;
            err_limit = ERROR_LIMIT_RESET;
            mode = LOCK_SETUP;
            digits = 0;
            foreach (code[i]) code[i] = KEY_NONE;
            mismatch = 1'b0;
            errors = '0;
            timer = '0;
            leds = '0;
            faults = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_SHORT_TICKS: short_ticks = data;
                CFG_LONG_TICKS:  long_ticks = data;
                CFG_ERROR_LIMIT: err_limit = data[3:0];
                default: ;
            endcase
        endfunction

        function void note_word(t_in_word w);
            t_out_word due;
            logic [2:0] ev;
            bit pressed;
            ev = EV_NONE;
            pressed = (w.cmd == CMD_KEY) && (w.key != KEY_NONE);
            case (mode)
                LOCK_SETUP: begin
                    if (w.cmd == CMD_BLINK) begin
                        leds ^= 3'b101;
                    end else if (pressed) begin
                        code[digits] = w.key;
                        digits++;
                        if (digits >= CODE_LENGTH) begin
                            mode = LOCK_ENTRY;
                            digits = 0;
                            mismatch = 1'b0;
                            leds = '0;
                            ev = EV_STORED;
                        end
                    end
                end
                LOCK_ENTRY: begin
                    if (pressed) begin
                        if (code[digits] != w.key) mismatch = 1'b1;
                        digits++;
                        if (digits >= CODE_LENGTH) begin
                            digits = CODE_LENGTH;
                            if (!mismatch) begin
                                mode = LOCK_OPEN;
                                digits = 0;
                                errors = '0;
                                leds = 3'b111;
                                ev = EV_ACCEPTED;
                            end else begin
                                timer = (errors >= err_limit) ? long_ticks : short_ticks;
                                if (errors < ERROR_MAX) errors++;
                                mode = LOCK_BLOCKED;
                                leds = '0;
                                ev = EV_REJECTED;
                            end
                            mismatch = 1'b0;
                        end
                    end
                end
                LOCK_BLOCKED: begin
                    if (w.cmd == CMD_BLINK) begin
                        leds ^= 3'b111;
                    end else if (w.cmd == CMD_TICK) begin
                        if (timer <= 16'd1) begin
                            timer = '0;
                            mode = LOCK_ENTRY;
                            digits = 0;
                            mismatch = 1'b0;
                            leds = '0;
                            ev = EV_LOCKOUT_OVER;
                        end else begin
                            timer--;
                        end
                    end
                end
                default: begin
                    if (w.cmd == CMD_KEY && w.key == KEY_ONE) begin
                        mode = LOCK_ENTRY;
                        digits = 0;
                        mismatch = 1'b0;
                        leds = '0;
                        ev = EV_CLOSED;
                    end
                end
            endcase
            due.mode = mode;
            due.digits_entered = 3'(digits);
            due.event_res = ev;
            due.leds = leds;
            status_due.push_back(due);
        endfunction

        function void compare_field(string name, logic [2:0] want, logic [2:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                faults++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (status_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, got);
                faults++;
                return;
            end
            want = status_due.pop_front();
            compare_field("mode", 3'(want.mode), 3'(got.mode));
            compare_field("digits_entered", want.digits_entered, got.digits_entered);
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("leds", want.leds, got.leds);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    lock_shadow lock_sb;
    bit         quiet;
    bit         try_good;
    int         bad_pos;

    combination_lock_with_lockout_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] wrong_key(logic [1:0] k);
        return 2'((k % 3) + 1);
    endfunction

    function automatic t_in_word pick_word();
        t_in_word w;
        int r;
        r = $urandom_range(0, 99);
        w.cmd = CMD_KEY;
        w.key = 2'($urandom_range(1, 3));
        case (lock_sb.mode)
            LOCK_ENTRY: begin
                if (r < 8) w.cmd = CMD_BLINK;
                else if (r < 12) w.cmd = CMD_TICK;
                else if (r < 14) w.cmd = CMD_UNUSED;
                else if (r < 16) w.key = KEY_NONE;
                else begin
                    if (lock_sb.digits == 0) begin
                        try_good = $urandom_range(0, 1);
                        bad_pos = $urandom_range(0, CODE_LENGTH - 1);
                    end
                    w.key = lock_sb.code[lock_sb.digits];
                    if (!try_good && lock_sb.digits == bad_pos) w.key = wrong_key(w.key);
                end
            end
            LOCK_BLOCKED: begin
                if (r < 70) w.cmd = CMD_TICK;
                else if (r < 85) w.cmd = CMD_BLINK;
                else if (r < 95) w.key = 2'($urandom_range(0, 3));
                else w.cmd = CMD_UNUSED;
            end
            LOCK_OPEN: begin
                if (r < 35) w.key = KEY_ONE;
                else if (r < 60) w.key = 2'($urandom_range(2, 3));
                else if (r < 75) w.cmd = CMD_BLINK;
                else if (r < 90) w.cmd = CMD_TICK;
                else if (r < 95) w.key = KEY_NONE;
                else w.cmd = CMD_UNUSED;
            end
            default: begin
                if (r >= 80) w.cmd = CMD_BLINK;
            end
        endcase
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        lock_sb.note_word(w);
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [1:0] key);
        t_in_word w;
        w.cmd = cmd;
        w.key = key;
        send_word(w);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (lock_sb.status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] s_ticks, input logic [15:0] l_ticks,
                                 input logic [3:0] limit);
        logic [1:0]  idx [3];
        logic [15:0] val [3];
        idx[0] = CFG_SHORT_TICKS;
        idx[1] = CFG_LONG_TICKS;
        idx[2] = CFG_ERROR_LIMIT;
        val[0] = s_ticks;
        val[1] = l_ticks;
        val[2] = {12'd0, limit};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            lock_sb.set_reg(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drive_to_entry();
        while (!(lock_sb.mode == LOCK_ENTRY && lock_sb.digits == 0)) begin
            case (lock_sb.mode)
                LOCK_BLOCKED: send_cmd(CMD_TICK, KEY_NONE);
                LOCK_OPEN:    send_cmd(CMD_KEY, KEY_ONE);
                default:      send_cmd(CMD_KEY, lock_sb.code[lock_sb.digits]);
            endcase
        end
    endtask

    task automatic run_phase(input logic [15:0] s_ticks, input logic [15:0] l_ticks,
                             input logic [3:0] limit, input int count);
        settle();
        load_settings(s_ticks, l_ticks, limit);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_word(pick_word());
        end
        quiet = 1'b0;
    endtask

    task automatic longest_lockout();
        logic [1:0] k;
        settle();
        load_settings(16'd120, 16'd120, 4'd15);
        quiet = 1'b1;
        drive_to_entry();
        for (int p = 0; p < CODE_LENGTH; p++) begin
            k = lock_sb.code[p];
            if (p == 0) k = wrong_key(k);
            send_cmd(CMD_KEY, k);
        end
        while (lock_sb.mode == LOCK_BLOCKED) send_cmd(CMD_TICK, KEY_NONE);
        quiet = 1'b0;
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            int stall;
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            lock_sb.check_word(o_out_word);
        end
    end

    initial begin
        lock_sb = new();
        quiet = 1'b0;
        try_good = 1'b1;
        bad_pos = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Setup with stray commands, then the code 3 1 2 3 2 1.
        send_cmd(CMD_BLINK, KEY_NONE);
        send_cmd(CMD_KEY, KEY_NONE);
        send_cmd(CMD_UNUSED, 2'd3);
        send_cmd(CMD_TICK, KEY_ONE);
        send_cmd(CMD_KEY, 2'd3);
        send_cmd(CMD_KEY, 2'd1);
        send_cmd(CMD_KEY, 2'd2);
        send_cmd(CMD_KEY, 2'd3);
        send_cmd(CMD_KEY, 2'd2);
        send_cmd(CMD_KEY, 2'd1);
        send_cmd(CMD_BLINK, KEY_NONE);
        send_cmd(CMD_TICK, KEY_NONE);
        send_cmd(CMD_KEY, 2'd3);
        send_cmd(CMD_KEY, 2'd1);
        send_cmd(CMD_KEY, 2'd2);
        send_cmd(CMD_KEY, 2'd3);
        send_cmd(CMD_KEY, 2'd2);
        send_cmd(CMD_KEY, 2'd1);
        send_cmd(CMD_KEY, 2'd3);
        send_cmd(CMD_KEY, KEY_ONE);

        // A zero error limit always picks the long lockout.
        settle();
        load_settings(16'd1, 16'd2, 4'd0);
        send_cmd(CMD_KEY, 2'd1);
        send_cmd(CMD_KEY, 2'd1);
        send_cmd(CMD_KEY, 2'd2);
        send_cmd(CMD_KEY, 2'd3);
        send_cmd(CMD_KEY, 2'd2);
        send_cmd(CMD_KEY, 2'd1);
        send_cmd(CMD_KEY, 2'd2);
        send_cmd(CMD_BLINK, KEY_NONE);
        send_cmd(CMD_TICK, KEY_NONE);
        send_cmd(CMD_TICK, KEY_NONE);

        run_phase(SHORT_TICKS_RESET, LONG_TICKS_RESET, ERROR_LIMIT_RESET, 220);
        run_phase(16'd1, 16'd1, 4'd0, 220);
        run_phase(16'd2, 16'd7, 4'd15, 220);
        longest_lockout();
        run_phase(16'hFFFF, 16'd1, 4'd0, 240);
        run_phase(16'd3, 16'd5, 4'd1, 240);
        run_phase(16'($urandom_range(1, 10)), 16'($urandom_range(1, 20)),
                  4'($urandom_range(0, 15)), 240);

        settle();
        repeat (16) @(posedge i_clk);
        if (lock_sb.faults == 0 && lock_sb.status_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/cll_pkg.sv
hdl/cll_code_mem.sv
hdl/cll_ctrl.sv
hdl/cll_out_buf.sv
hdl/combination_lock_with_lockout_top.sv
bench/combination_lock_with_lockout_top_tb.sv
